### rtl/core/edit_distance_engine_assert.svh
// ----------------------------------------------------------------------------
// Edit distance engine assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef EDIT_DISTANCE_ENGINE_ASSERT_SVH
`define EDIT_DISTANCE_ENGINE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define EDE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define EDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/edc_pkg.sv
// ----------------------------------------------------------------------------
// Edit distance engine package
// Shared constants, command codes, controller states and cell control type.
// ----------------------------------------------------------------------------
package edc_pkg;

  // default string capacity per string
  localparam int MaxLenDefault = 64;

  // field widths
  localparam int CmdW  = 2;
  localparam int CharW = 8;
  localparam int DistW = 7;

  // largest distance the result field can carry
  localparam int DistMax = 127;

  // command codes
  typedef enum logic [CmdW-1:0] {
    CmdAppendA = 2'd0,
    CmdAppendB = 2'd1,
    CmdCompute = 2'd2
  } cmd_e;

  // controller states
  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StDone
  } state_e;

  // per-cell control
  typedef struct packed {
    logic init;  // reload the column value before a pass
    logic b_we;  // store the incoming string b character
  } cell_ctrl_t;

endpackage

### rtl/core/edc_cell.sv
// ----------------------------------------------------------------------------
// Edit distance cell
// One column of the dynamic program: holds one string b character and the
// current column value, and passes string a characters to its right neighbor.
// ----------------------------------------------------------------------------
module edc_cell #(
  parameter int ValW  = 7,
  parameter int Index = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  edc_pkg::cell_ctrl_t         ctrl_i,
  input  logic [edc_pkg::CharW-1:0]   char_i,
  input  logic                        a_valid_i,
  input  logic [edc_pkg::CharW-1:0]   a_char_i,
  input  logic [ValW-1:0]             left_new_i,
  input  logic [ValW-1:0]             left_old_i,
  output logic                        a_valid_o,
  output logic [edc_pkg::CharW-1:0]   a_char_o,
  output logic [ValW-1:0]             value_o,
  output logic [ValW-1:0]             old_o
);

  logic                      valid_q;
  logic [edc_pkg::CharW-1:0] b_q;
  logic [edc_pkg::CharW-1:0] a_char_q;
  logic [ValW-1:0]           value_q;
  logic [ValW-1:0]           value_d;
  logic [ValW-1:0]           old_q;
  logic [ValW-1:0]           min_ul;
  logic [ValW-1:0]           min_all;

  // unit-cost recurrence: match takes the diagonal, else min of three plus one
  always_comb begin
    min_ul  = (value_q < left_new_i) ? value_q : left_new_i;
    min_all = (min_ul < left_old_i) ? min_ul : left_old_i;
    if (a_char_i == b_q) begin
      value_d = left_old_i;
    end else begin
      value_d = min_all + ValW'(1);
    end
  end

  // valid travels one cell per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.init) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= a_valid_i;
    end
  end

  // column state and forwarded character
  always_ff @(posedge clk_i) begin
    if (ctrl_i.b_we) begin
      b_q <= char_i;
    end
    if (ctrl_i.init) begin
      value_q <= ValW'(Index + 1);
    end else if (a_valid_i) begin
      value_q  <= value_d;
      old_q    <= value_q;
      a_char_q <= a_char_i;
    end
  end

  assign a_valid_o = valid_q;
  assign a_char_o  = a_char_q;
  assign value_o   = value_q;
  assign old_o     = old_q;

endmodule

### rtl/core/edc_ctrl.sv
// ----------------------------------------------------------------------------
// Edit distance controller
// Command decode, string a storage, string lengths, wavefront feed into the
// cell chain and the result and output registers.
// ----------------------------------------------------------------------------
module edc_ctrl #(
  parameter int MaxLen = edc_pkg::MaxLenDefault,
  parameter int LenW   = $clog2(MaxLen + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [edc_pkg::CmdW-1:0]    command_i,
  input  logic [edc_pkg::CharW-1:0]   character_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [edc_pkg::DistW-1:0]  distance_o,
  output logic                        overflow_o,
  output logic                        init_o,
  output logic                        wr_b_o,
  output logic [LenW-1:0]             len_b_o,
  output logic                        feed_valid_o,
  output logic [edc_pkg::CharW-1:0]   feed_char_o,
  output logic [LenW-1:0]             feed_new_o,
  output logic [LenW-1:0]             feed_old_o,
  output logic [LenW-1:0]             sel_idx_o,
  input  logic [LenW-1:0]             sel_value_i
);

  localparam int AddrW = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int CntW  = $clog2(2 * MaxLen + 1);
  localparam int SatW  = (LenW > edc_pkg::DistW) ? LenW : edc_pkg::DistW;

  edc_pkg::state_e state_q, state_d;
  edc_pkg::cmd_e   cmd;

  logic [edc_pkg::CharW-1:0] string_a [MaxLen];

  logic [LenW-1:0]           len_a_q, len_b_q, m_q, n_q;
  logic                      dropped_q;
  logic [CntW-1:0]           cnt_q;
  logic [CntW-1:0]           total;
  logic                      feed_valid_q, feed_valid_d;
  logic [LenW-1:0]           feed_idx_q;
  logic [edc_pkg::CharW-1:0] feed_char_q;
  logic [edc_pkg::DistW-1:0] res_dist_q;
  logic                      res_ovf_q;
  logic                      out_valid_q;
  logic [edc_pkg::DistW-1:0] out_dist_q;
  logic                      out_ovf_q;

  logic                      in_ready, running, try_out;
  logic                      accept, is_compute, empty_pair, start, run_end;
  logic                      wr_a, wr_b;
  logic [LenW-1:0]           res_src;
  logic [SatW-1:0]           res_ext;
  logic [edc_pkg::DistW-1:0] res_sat;

  // command decode
  assign cmd        = edc_pkg::cmd_e'(command_i);
  assign accept     = in_valid_i && in_ready;
  assign is_compute = accept && (cmd == edc_pkg::CmdCompute);
  assign empty_pair = (len_a_q == '0) || (len_b_q == '0);
  assign start      = is_compute && !empty_pair;
  assign wr_a       = accept && (cmd == edc_pkg::CmdAppendA) && (len_a_q != LenW'(MaxLen));
  assign wr_b       = accept && (cmd == edc_pkg::CmdAppendB) && (len_b_q != LenW'(MaxLen));
  assign total      = CntW'(m_q) + CntW'(n_q);
  assign run_end    = running && (cnt_q == total);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      edc_pkg::StIdle: begin
        if (is_compute) begin
          state_d = empty_pair ? edc_pkg::StDone : edc_pkg::StRun;
        end
      end
      edc_pkg::StRun: begin
        if (run_end) begin
          state_d = edc_pkg::StDone;
        end
      end
      edc_pkg::StDone: begin
        if (try_out) begin
          state_d = edc_pkg::StIdle;
        end
      end
      default: state_d = edc_pkg::StIdle;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    running  = 1'b0;
    try_out  = 1'b0;
    case (state_q)
      edc_pkg::StIdle: in_ready = 1'b1;
      edc_pkg::StRun:  running  = 1'b1;
      edc_pkg::StDone: try_out  = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // result saturation: empty pair takes the longer length, else the chain value
  always_comb begin
    res_src = (len_a_q > len_b_q) ? len_a_q : len_b_q;
    if (running) begin
      res_src = sel_value_i;
    end
    res_ext = SatW'(res_src);
    if (res_ext > SatW'(edc_pkg::DistMax)) begin
      res_sat = edc_pkg::DistW'(edc_pkg::DistMax);
    end else begin
      res_sat = res_ext[edc_pkg::DistW-1:0];
    end
  end

  // feed next string a character while the pass still has rows to issue
  assign feed_valid_d = running && (cnt_q < CntW'(m_q));

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= edc_pkg::StIdle;
      len_a_q      <= '0;
      len_b_q      <= '0;
      dropped_q    <= 1'b0;
      cnt_q        <= '0;
      feed_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      feed_valid_q <= feed_valid_d;
      if (wr_a) begin
        len_a_q <= len_a_q + LenW'(1);
      end
      if (wr_b) begin
        len_b_q <= len_b_q + LenW'(1);
      end
      if (accept && !wr_a && (cmd == edc_pkg::CmdAppendA)) begin
        dropped_q <= 1'b1;
      end
      if (accept && !wr_b && (cmd == edc_pkg::CmdAppendB)) begin
        dropped_q <= 1'b1;
      end
      if (is_compute) begin
        len_a_q   <= '0;
        len_b_q   <= '0;
        dropped_q <= 1'b0;
      end
      if (start) begin
        cnt_q <= '0;
      end else if (running) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (try_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // string a memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      string_a[len_a_q[AddrW-1:0]] <= character_i;
    end
    if (feed_valid_d) begin
      feed_char_q <= string_a[cnt_q[AddrW-1:0]];
      feed_idx_q  <= LenW'(cnt_q) + LenW'(1);
    end
  end

  // pass lengths, result and output payload
  always_ff @(posedge clk_i) begin
    if (is_compute) begin
      m_q       <= len_a_q;
      n_q       <= len_b_q;
      res_ovf_q <= dropped_q;
    end
    if (is_compute || run_end) begin
      res_dist_q <= res_sat;
    end
    if (try_out) begin
      out_dist_q <= res_dist_q;
      out_ovf_q  <= res_ovf_q;
    end
  end

  assign in_ready_o   = in_ready;
  assign out_valid_o  = out_valid_q;
  assign distance_o   = out_dist_q;
  assign overflow_o   = out_ovf_q;
  assign init_o       = start;
  assign wr_b_o       = wr_b;
  assign len_b_o      = len_b_q;
  assign feed_valid_o = feed_valid_q;
  assign feed_char_o  = feed_char_q;
  assign feed_new_o   = feed_idx_q;
  assign feed_old_o   = feed_idx_q - LenW'(1);
  assign sel_idx_o    = n_q;

endmodule

### rtl/core/edit_distance_engine.sv
// ----------------------------------------------------------------------------
// Edit distance engine
// Levenshtein distance between two byte strings on a systolic cell chain.
// ----------------------------------------------------------------------------
// Append commands and the unused command code complete on acceptance. A compute
// with both strings non-empty loads the chain, then streams string a through
// the MAX_LEN cells, one cell per cycle; the pass ends when the wavefront
// reaches the cell of the last string b character, and the result then goes
// to the output register before the next transaction is taken. A compute
// with an empty string skips the pass. Appends are taken while a finished
// result still waits in the output register.
module edit_distance_engine #(
  parameter int MaxLen = edc_pkg::MaxLenDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [edc_pkg::CmdW-1:0]    command_i,
  input  logic [edc_pkg::CharW-1:0]   character_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [edc_pkg::DistW-1:0]  distance_o,
  output logic                        overflow_o
);

  localparam int LenW = $clog2(MaxLen + 1);

  logic                      init;
  logic                      wr_b;
  logic [LenW-1:0]           len_b;
  logic [LenW-1:0]           sel_idx;

  // chain links, entry zero is the feed from the controller
  logic                      link_valid [MaxLen+1];
  logic [edc_pkg::CharW-1:0] link_char  [MaxLen+1];
  logic [LenW-1:0]           link_new   [MaxLen+1];
  logic [LenW-1:0]           link_old   [MaxLen+1];

  edc_ctrl #(
    .MaxLen (MaxLen),
    .LenW   (LenW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .character_i  (character_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .distance_o   (distance_o),
    .overflow_o   (overflow_o),
    .init_o       (init),
    .wr_b_o       (wr_b),
    .len_b_o      (len_b),
    .feed_valid_o (link_valid[0]),
    .feed_char_o  (link_char[0]),
    .feed_new_o   (link_new[0]),
    .feed_old_o   (link_old[0]),
    .sel_idx_o    (sel_idx),
    .sel_value_i  (link_new[sel_idx])
  );

  // one cell per string b position
  for (genvar j = 0; j < MaxLen; j++) begin : g_cell
    edc_pkg::cell_ctrl_t cell_ctrl;

    assign cell_ctrl.init = init;
    assign cell_ctrl.b_we = wr_b && (len_b == LenW'(j));

    edc_cell #(
      .ValW  (LenW),
      .Index (j)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .char_i     (character_i),
      .a_valid_i  (link_valid[j]),
      .a_char_i   (link_char[j]),
      .left_new_i (link_new[j]),
      .left_old_i (link_old[j]),
      .a_valid_o  (link_valid[j+1]),
      .a_char_o   (link_char[j+1]),
      .value_o    (link_new[j+1]),
      .old_o      (link_old[j+1])
    );
  end

endmodule

### rtl/core/edc_checker.sv
// ----------------------------------------------------------------------------
// Edit distance engine checker
// Port-level checks on busy behavior and result hand-off, bound to the top.
// ----------------------------------------------------------------------------
`include "edit_distance_engine_assert.svh"

module edc_checker #(
  parameter int MaxLen = edc_pkg::MaxLenDefault
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [edc_pkg::CmdW-1:0]    command_i,
  input logic [edc_pkg::CharW-1:0]   character_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [edc_pkg::DistW-1:0]  distance_o,
  input logic                        overflow_o
);

  // a stalled result transaction keeps its payload
  `EDE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(distance_o) && $stable(overflow_o), "result changed while stalled")

  // a compute transaction makes the engine busy in the next cycle
  `EDE_ASSERT_NEXT(a_compute_busy, in_valid_i && in_ready_o && (command_i == edc_pkg::CmdCompute), !in_ready_o, "input taken right after compute")

  // a new result only appears after a busy cycle
  `EDE_ASSERT_IMPL(a_result_after_busy, $rose(out_valid_o), !$past(in_ready_o), "result without a compute pass")

  // distance never exceeds the string capacity
  `EDE_ASSERT_IMPL(a_dist_bound, out_valid_o, (MaxLen > edc_pkg::DistMax) || (int'(distance_o) <= MaxLen), "distance above capacity")

  // character is payload only
  logic unused_char;
  assign unused_char = ^character_i;

endmodule

bind edit_distance_engine edc_checker #(.MaxLen(MaxLen)) u_edc_checker (.*);
